FILE: rtl/pol_pkg.sv
`default_nettype none
package pol_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int ENTRIES_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP       = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] item;
        logic [ENTRIES_W-1:0]     entries;
        logic                     final_res;
    } t_out_beat;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic step;
    } t_pol_cmd;

    // datapath -> controller
    typedef struct packed {
        logic dump_go;
        logic dump_last;
    } t_pol_stat;

endpackage
`default_nettype wire

FILE: rtl/pol_ctrl.sv
`default_nettype none
module pol_ctrl
    import pol_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_pol_stat i_stat,
    output t_pol_cmd       o_cmd
);

    typedef enum logic {S_IDLE, S_DUMP} t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall   = !((r_state == S_IDLE) && out_free);
    assign o_cmd.accept = (r_state == S_IDLE) && out_free && i_in_valid;
    assign o_cmd.step   = (r_state == S_DUMP) && out_free;
    assign o_out_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((o_cmd.accept && !i_stat.dump_go) || o_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept && i_stat.dump_go) begin
                        r_state <= S_DUMP;
                    end
                end
                S_DUMP: begin
                    if (o_cmd.step && i_stat.dump_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pol_dpath.sv
`default_nettype none
module pol_dpath
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_beat i_in_data,
    input  wire t_pol_cmd i_cmd,
    output t_pol_stat     o_stat,
    output t_out_beat     o_out_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [DATA_W-1:0] n_slot [DEPTH];
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     n_fill;
    logic [IW-1:0]     r_idx;
    t_out_beat         r_out;
    t_out_beat         n_out;

    logic [CMPW-1:0]     fill_x;
    logic [CMPW-1:0]     pos_x;
    logic [CMPW-1:0]     last_x;
    logic [CMPW-1:0]     at;
    logic                ins_ok;
    logic                del_ok;
    logic [STATUS_W-1:0] st;

    assign fill_x = CMPW'(r_fill);
    assign pos_x  = CMPW'(i_in_data.position);
    assign last_x = fill_x - CMPW'(1);

    assign o_stat.dump_go   = (i_in_data.command == CMD_DUMP) && (r_fill != '0);
    assign o_stat.dump_last = (CMPW'(r_idx) == last_x);
    assign o_out_data       = r_out;

    // decode of one edit beat
    always_comb begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        st     = ST_OK;
        at     = '0;
        unique case (i_in_data.command)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                if (fill_x == CMPW'(DEPTH)) begin
                    st = ST_FULL;
                end else if (i_in_data.command == CMD_INS_FRONT) begin
                    ins_ok = 1'b1;
                end else if (i_in_data.command == CMD_INS_BACK) begin
                    ins_ok = 1'b1;
                    at     = fill_x;
                end else if (pos_x == '0 || pos_x > fill_x + CMPW'(1)) begin
                    st = ST_RANGE;
                end else begin
                    ins_ok = 1'b1;
                    at     = pos_x - CMPW'(1);
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                if (fill_x == '0) begin
                    st = ST_EMPTY;
                end else if (i_in_data.command == CMD_DEL_FRONT) begin
                    del_ok = 1'b1;
                end else if (i_in_data.command == CMD_DEL_BACK) begin
                    del_ok = 1'b1;
                    at     = last_x;
                end else if (pos_x == '0 || pos_x > fill_x) begin
                    st = ST_RANGE;
                end else begin
                    del_ok = 1'b1;
                    at     = pos_x - CMPW'(1);
                end
            end
            CMD_DUMP: begin
                if (fill_x == '0) begin
                    st = ST_EMPTY;
                end
            end
            default: st = ST_OK;
        endcase
    end

    // cell row update
    always_comb begin
        n_slot = r_slot;
        n_fill = r_fill;
        n_out  = r_out;
        if (i_cmd.accept) begin
            if (ins_ok) begin
                n_slot[0] = (at == '0) ? i_in_data.value : r_slot[0];
                for (int i = 1; i < DEPTH; i++) begin
                    if (CMPW'(i) == at) begin
                        n_slot[i] = i_in_data.value;
                    end else if (CMPW'(i) > at) begin
                        n_slot[i] = r_slot[i-1];
                    end
                end
                n_fill = CW'(fill_x + CMPW'(1));
            end else if (del_ok) begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (CMPW'(i) >= at) begin
                        n_slot[i] = r_slot[i+1];
                    end
                end
                n_fill = CW'(last_x);
            end
            n_out.status    = st;
            n_out.item      = '0;
            n_out.entries   = ENTRIES_W'(CMPW'(n_fill));
            n_out.final_res = 1'b1;
        end else if (i_cmd.step) begin
            // rotate the live entries so the next one reaches the head
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (CMPW'(i) == last_x) begin
                    n_slot[i] = r_slot[0];
                end else if (CMPW'(i) < last_x) begin
                    n_slot[i] = r_slot[i+1];
                end
            end
            if (CMPW'(DEPTH - 1) == last_x) begin
                n_slot[DEPTH-1] = r_slot[0];
            end
            n_out.status    = ST_OK;
            n_out.item      = r_slot[0];
            n_out.entries   = ENTRIES_W'(fill_x);
            n_out.final_res = o_stat.dump_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= o_stat.dump_last ? '0 : r_idx + IW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/positional_ordered_list_core.sv
// channel | direction | handshake                | beat type
// in      | input     | i_in_valid / o_in_stall   | t_in_beat
// out     | output    | o_out_valid / i_out_stall | t_out_beat
//
// Edits (insert, delete, no-op, dump of an empty list) give one result each;
// an insert or delete shifts the whole cell row as its result is registered.
// A dump beat gives no result; the row then rotates one entry per result
// past the head cell. Reset (synchronous, active low) empties the list; no
// clearing pass. Output stall holds the result register; input stall rises
// only while a dump runs or an unread result would be overwritten.
`default_nettype none
module positional_ordered_list_core
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_beat i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_beat     o_out_data
);

    t_pol_cmd  cmd;
    t_pol_stat stat;

    pol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pol_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/pol_chk.sv
`default_nettype none
module pol_chk
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_beat  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_data
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed under stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed under stall");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK
            |-> o_out_data.item == '0 && o_out_data.final_res)
        else $error("error beat carries item or is not final");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL
            |-> o_out_data.entries == ENTRIES_W'(DEPTH))
        else $error("full status with wrong count");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY
            |-> o_out_data.entries == '0)
        else $error("empty status with nonzero count");

endmodule

bind positional_ordered_list_core pol_chk #(
    .DEPTH (DEPTH)
) u_pol_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
    import pol_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_in_beat beat;
        bit       drain;
    } t_cmd_slot;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_data;

    t_cmd_slot cmd_backlog[$];
    t_out_beat results_due[$];

    logic signed [DATA_W-1:0] list_vals[DEPTH_DEF];
    int list_len = 0;
    int beats_in = 0;
    int fails = 0;
    int quiet = 0;

    wire calm = (beats_in >= 150 && beats_in < 210);

    positional_ordered_list_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial forever #2 clk = ~clk;

    function automatic void push_result(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] v,
                                        bit last);
        t_out_beat r;
        r.status    = st;
        r.item      = v;
        r.entries   = ENTRIES_W'(list_len);
        r.final_res = last;
        results_due.push_back(r);
    endfunction

    // updates the list image and queues the results one command produces
    function automatic void apply_command(t_in_beat b);
        logic [STATUS_W-1:0] st;
        int p;
        int idx;
        st = ST_OK;
        p = int'(b.position);
        case (b.command)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                if (list_len >= DEPTH_DEF) begin
                    st = ST_FULL;
                end else if (b.command == CMD_INS_POS && (p < 1 || p > list_len + 1)) begin
                    st = ST_RANGE;
                end else begin
                    idx = (b.command == CMD_INS_FRONT) ? 0 :
                          (b.command == CMD_INS_BACK) ? list_len : p - 1;
                    for (int i = list_len; i > idx; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[idx] = b.value;
                    list_len++;
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else if (b.command == CMD_DEL_POS && (p < 1 || p > list_len)) begin
                    st = ST_RANGE;
                end else begin
                    idx = (b.command == CMD_DEL_FRONT) ? 0 :
                          (b.command == CMD_DEL_BACK) ? list_len - 1 : p - 1;
                    for (int i = idx; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            CMD_DUMP: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_len; i++)
                        push_result(ST_OK, list_vals[i], i + 1 == list_len);
                    return;
                end
            end
            default: ;
        endcase
        push_result(st, '0, 1'b1);
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v,
                                      int p, bit drain = 1'b0);
        t_cmd_slot s;
        s.beat.command  = c;
        s.beat.value    = v;
        s.beat.position = POS_W'(p);
        s.drain         = drain;
        cmd_backlog.push_back(s);
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_command(in_data);
                beats_in++;
            end
            if (!in_valid || !in_stall) begin
                if (cmd_backlog.size() == 0 ||
                    (cmd_backlog[0].drain && results_due.size() != 0) ||
                    (!calm && $urandom_range(99) < 24)) begin
                    in_valid <= 1'b0;
                end else begin
                    in_data  <= cmd_backlog[0].beat;
                    in_valid <= 1'b1;
                    void'(cmd_backlog.pop_front());
                end
            end
        end
    end

    // sink stall
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 24);
    end

    // monitor
    always @(posedge clk) begin
        t_out_beat e;
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected result beat: status %0d item %0d entries %0d final %0d",
                       out_data.status, out_data.item, out_data.entries, out_data.final_res);
                fails++;
            end else begin
                e = results_due.pop_front();
                if (out_data.status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, out_data.status);
                    fails++;
                end
                if (out_data.item !== e.item) begin
                    $error("item expected %0d got %0d", e.item, out_data.item);
                    fails++;
                end
                if (out_data.entries !== e.entries) begin
                    $error("entries expected %0d got %0d", e.entries, out_data.entries);
                    fails++;
                end
                if (out_data.final_res !== e.final_res) begin
                    $error("final_res expected %0d got %0d", e.final_res, out_data.final_res);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= 5000) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int gl;
        bit grow;
        int r;
        logic [CMD_W-1:0] c;
        logic signed [DATA_W-1:0] v;
        int p;

        // directed
        queue_cmd(CMD_DUMP, 0, 0);
        queue_cmd(CMD_DEL_FRONT, 0, 0);
        queue_cmd(CMD_DEL_BACK, 0, 0);
        queue_cmd(CMD_DEL_POS, 0, 1);
        queue_cmd(CMD_INS_POS, 5, 0);
        queue_cmd(CMD_INS_POS, 6, 2);
        queue_cmd(CMD_INS_POS, 32'sh8000_0000, 1);
        queue_cmd(CMD_INS_FRONT, 32'sh7fff_ffff, 0);
        queue_cmd(CMD_INS_BACK, -1, 0);
        queue_cmd(CMD_INS_POS, 0, 4);
        queue_cmd(CMD_INS_POS, 7, 31);
        queue_cmd(CMD_DUMP, 0, 0);
        queue_cmd(CMD_DEL_POS, 0, 0);
        queue_cmd(CMD_DEL_POS, 0, 5);
        queue_cmd(CMD_DEL_POS, 0, 2);
        queue_cmd(CMD_NOP, 32'sh5a5a_a5a5, 31);
        queue_cmd(CMD_DUMP, 0, 0);
        queue_cmd(CMD_DEL_BACK, 0, 0);
        queue_cmd(CMD_DEL_FRONT, 0, 0);
        queue_cmd(CMD_DEL_FRONT, 0, 0);
        queue_cmd(CMD_DUMP, 0, 0);

        // random: alternate filling and emptying runs so full and empty are hit often
        gl = 0;
        grow = 1'b1;
        for (int n = 0; n < 290; n++) begin
            if (grow && gl >= DEPTH_DEF && $urandom_range(3) == 0)
                grow = 1'b0;
            else if (!grow && gl == 0 && $urandom_range(3) == 0)
                grow = 1'b1;
            r = $urandom_range(99);
            if (r < 65)
                c = grow ? CMD_W'(CMD_INS_FRONT + $urandom_range(2)) :
                           CMD_W'(CMD_DEL_FRONT + $urandom_range(2));
            else if (r < 85)
                c = grow ? CMD_W'(CMD_DEL_FRONT + $urandom_range(2)) :
                           CMD_W'(CMD_INS_FRONT + $urandom_range(2));
            else if (r < 93)
                c = CMD_DUMP;
            else if (r < 97)
                c = CMD_NOP;
            else
                c = CMD_W'($urandom_range(7));
            case ($urandom_range(9))
                0: v = 32'sh8000_0000;
                1: v = 32'sh7fff_ffff;
                2: v = $urandom_range(1) ? 0 : -1;
                default: v = $urandom;
            endcase
            if ($urandom_range(99) < 15)
                p = $urandom_range(31);
            else if (c <= CMD_INS_POS)
                p = $urandom_range(gl + 1, 1);
            else
                p = (gl > 0) ? $urandom_range(gl, 1) : 0;
            queue_cmd(c, v, p, n == 20 || n == 260);
            // track the count only, to steer the runs
            if (c <= CMD_INS_POS) begin
                if (gl < DEPTH_DEF && (c != CMD_INS_POS || (p >= 1 && p <= gl + 1)))
                    gl++;
            end else if (c <= CMD_DEL_POS) begin
                if (gl > 0 && (c != CMD_DEL_POS || (p >= 1 && p <= gl)))
                    gl--;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
